// ----- rtl/core/rfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rfs_pkg;

  localparam int DATA_W        = 32;
  localparam int KIND_W        = 2;
  localparam int CAP_W         = 5;
  localparam int CNT_W         = 5;
  localparam int DEPTH_DEFAULT = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH
  } state_t;

  // one result as it leaves the controller
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] popped;
    logic [CNT_W-1:0]         occupancy;
    logic                     is_full;
    logic                     is_empty;
  } result_t;

  // capacity in effect: zero acts as one, above the depth acts as the depth
  function automatic logic [CAP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap,
                                                    input int depth);
    logic [CAP_W-1:0] c;
    c = cap;
    if (c == '0) c = CAP_W'(1);
    if (int'(c) > depth) c = CAP_W'(depth);
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rfs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rfs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/rfs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rfs_ctrl #(
  parameter int DEPTH  = rfs_pkg::DEPTH_DEFAULT,
  parameter int ADDR_W = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rfs_pkg::op_t                      in_kind,
  input  wire logic signed [rfs_pkg::DATA_W-1:0] in_value,
  input  wire logic                              out_free,
  output logic                                   res_valid,
  output rfs_pkg::result_t                       res,
  input  wire logic [rfs_pkg::CAP_W-1:0]         eff_cap,
  input  wire logic                              cfg_clear,
  output logic                                   wr_en,
  output logic [ADDR_W-1:0]                      wr_addr,
  output logic [rfs_pkg::DATA_W-1:0]             wr_data,
  output logic [ADDR_W-1:0]                      rd_addr,
  input  wire logic [rfs_pkg::DATA_W-1:0]        rd_data
);

  import rfs_pkg::*;

  state_t               state, state_next;
  logic [ADDR_W-1:0]    head, head_next;
  logic [ADDR_W-1:0]    tail, tail_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [ADDR_W-1:0]    pos, pos_next;
  logic [CNT_W-1:0]     left, left_next;
  logic [DATA_W-1:0]    key, key_next;
  logic                 accept;
  logic                 hit;

  function automatic logic [ADDR_W-1:0] step(input logic [ADDR_W-1:0] i,
                                             input logic [CAP_W-1:0] cap);
    logic [ADDR_W-1:0] n;
    n = ADDR_W'(int'(i) + 1);
    if (int'(i) + 1 >= int'(cap)) n = '0;
    return n;
  endfunction

  assign accept = in_valid && out_free && (state == ST_IDLE);
  assign hit    = (rd_data == key);

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    pos_next      = pos;
    left_next     = left;
    key_next      = key;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    res.ok        = 1'b0;
    res.popped    = '0;
    wr_en         = 1'b0;
    wr_addr       = tail;
    wr_data       = in_value;
    rd_addr       = head;
    case (state)
      ST_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          case (in_kind)
            OP_PUSH: begin
              res_valid = 1'b1;
              if (int'(count) < int'(eff_cap)) begin
                wr_en      = 1'b1;
                tail_next  = step(tail, eff_cap);
                count_next = count + CNT_W'(1);
                res.ok     = 1'b1;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                res_valid = 1'b1;
              end else begin
                state_next = ST_POP;
              end
            end
            OP_CLEAR: begin
              res_valid  = 1'b1;
              res.ok     = 1'b1;
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
            end
            OP_SEARCH: begin
              if (count == '0) begin
                res_valid = 1'b1;
              end else begin
                pos_next   = step(head, eff_cap);
                left_next  = count - CNT_W'(1);
                key_next   = in_value;
                state_next = ST_SEARCH;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        // head entry read last cycle
        res_valid  = 1'b1;
        res.ok     = 1'b1;
        res.popped = rd_data;
        count_next = count - CNT_W'(1);
        if (count_next == '0) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          head_next = step(head, eff_cap);
        end
        state_next = ST_IDLE;
      end
      ST_SEARCH: begin
        // compare the entry read last cycle, issue the next read
        if (hit || left == '0) begin
          res_valid  = 1'b1;
          res.ok     = hit;
          state_next = ST_IDLE;
        end else begin
          rd_addr   = pos;
          pos_next  = step(pos, eff_cap);
          left_next = left - CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    res.occupancy = count_next;
    res.is_full   = (count_next == eff_cap);
    res.is_empty  = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cfg_clear) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    left <= left_next;
    key  <= key_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= int'(eff_cap))
    else $error("occupancy above capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    int'(head) < int'(eff_cap) && int'(tail) < int'(eff_cap))
    else $error("pointer outside capacity");

  a_empty_home: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == '0 && tail == '0)
    else $error("empty queue with pointers off home");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result issued while output register full");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> count == $past(count) + CNT_W'(1))
    else $error("slot write without occupancy step");

  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    eff_cap != '0 && int'(eff_cap) <= DEPTH)
    else $error("capacity in effect outside the slot depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ring_fifo_with_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Circular FIFO of signed 32-bit words with a key search.
// Input stream (s_*): s_tuser holds the operation (push, pop, clear, search),
// s_tdata the word to push or the key to search for. One input transaction
// gives exactly one output transaction on m_*: m_tuser is the ok flag,
// m_tdata carries the popped word, the occupancy and the full/empty flags.
// Configuration: cfg_we with cfg_wdata writes the capacity (zero acts as one,
// above DEPTH acts as DEPTH) and empties the queue; write only while idle.
// Push, clear, a refused pop and a search of an empty queue load their result
// into the output register from the accept; a pop first reads the head entry
// from the slot RAM, whose read is registered; a search reads one slot RAM
// entry per cycle from the oldest entry up to the first match, or through the
// whole occupancy when the key is absent. Push and clear are taken once per
// cycle while the receiver is ready; pop and search hold s_tready low until
// their result is issued. The next transaction is taken at the edge where the
// previous result leaves, never while it waits on m_tready.
// Reset (rst, synchronous): queue empty, capacity 16, no result pending.
// Slot contents are not cleared; only written entries are ever read.
// When the receiver stalls, the result holds in the output register and
// s_tready stays low until it is taken.

module ring_fifo_with_search_top #(
  parameter int DEPTH = rfs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rfs_pkg::DATA_W-1:0]    s_tdata,   // [31:0] value
  input  wire logic [rfs_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [31:0] popped, [36:32] occupancy, [37] is_full, [38] is_empty, [39] zero
  output logic [39:0]                        m_tdata,
  output logic                               m_tuser,   // [0] ok
  input  wire logic                          cfg_we,
  input  wire logic [rfs_pkg::CAP_W-1:0]     cfg_wdata
);

  import rfs_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]   capacity;
  logic [CAP_W-1:0]   eff_cap;
  logic               out_free;
  logic               res_valid;
  result_t            res;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DATA_W-1:0]  rd_data;

  // capacity register; the controller empties the queue on the same write
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign eff_cap  = eff_capacity(capacity, DEPTH);

  // output register may take a result when empty or draining this cycle
  assign out_free = !m_tvalid || m_tready;

  rfs_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (op_t'(s_tuser)),
    .in_value  (s_tdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .eff_cap   (eff_cap),
    .cfg_clear (cfg_we),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  rfs_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: load a fresh result, drop the valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tuser <= res.ok;
      m_tdata <= {1'b0, res.is_empty, res.is_full, res.occupancy, res.popped};
    end
  end

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> u_ctrl.count == '0)
    else $error("capacity write left entries");
`endif

endmodule

`default_nettype wire

// ----- test/tb_ring_fifo_with_search_top.sv -----
`timescale 1ns / 1ps

module tb_ring_fifo_with_search_top;
  import rfs_pkg::*;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int CYCLE_CAP  = 200000;   // far above the slowest legal run
  localparam int PHASE_LEN  = 66;       // random transactions per capacity setting
  localparam int REPORT_MAX = 10;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    RDY_OPEN,     // always ready
    RDY_COIN,     // ready half the time
    RDY_SPARSE,   // ready a quarter of the time, at random
    RDY_PERIODIC  // periodic stall, from the cycle counter
  } rdy_mode_t;

  typedef struct {
    op_t         kind;
    logic [31:0] value;
  } fifo_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;   // [31:0] value
  logic [KIND_W-1:0]     s_tuser = '0;   // [1:0] kind
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;        // [31:0] popped, [36:32] occupancy, [37] full, [38] empty
  logic                  m_tuser;        // [0] ok
  logic                  cfg_we = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata = '0;

  ring_fifo_with_search_top #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Clock, reset and run limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  int unsigned cyc = 0;

  // Abort a hung run: nothing legal gets near this count.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow FIFO: tracks the queue contents and computes each expected result
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] slot_mem [DEPTH];
  logic [3:0]               rd_ptr;
  logic [3:0]               wr_ptr;
  logic [CNT_W-1:0]         fill;
  logic [CAP_W-1:0]         cap_reg;

  // Clamp the programmed capacity: zero behaves as one, anything past the
  // depth behaves as the depth.
  function automatic logic [CAP_W-1:0] cap_in_effect();
    logic [CAP_W-1:0] c;
    c = cap_reg;
    if (c == '0) c = CAP_W'(1);
    if (c > CAP_W'(DEPTH)) c = CAP_W'(DEPTH);
    return c;
  endfunction

  // Advance a pointer, wrapping at the capacity in effect.
  function automatic logic [3:0] ptr_step(input logic [3:0] p);
    logic [4:0] n;
    n = {1'b0, p} + 5'd1;
    if (n >= cap_in_effect()) n = '0;
    return n[3:0];
  endfunction

  task automatic flush();
    rd_ptr = '0;
    wr_ptr = '0;
    fill   = '0;
  endtask

  // Apply one operation to the shadow queue and build the result it gives.
  task automatic fifo_op(input op_t kind, input logic [31:0] v, output result_t r);
    logic [CAP_W-1:0] cap;
    logic [3:0]       pos;
    logic             hit;
    logic [31:0]      out_word;
    cap      = cap_in_effect();
    hit      = 1'b0;
    out_word = '0;
    case (kind)
      OP_PUSH: begin
        if (fill < cap) begin
          slot_mem[wr_ptr] = v;
          wr_ptr = ptr_step(wr_ptr);
          fill   = fill + CNT_W'(1);
          hit    = 1'b1;
        end
      end
      OP_POP: begin
        if (fill != 0) begin
          out_word = slot_mem[rd_ptr];
          rd_ptr = ptr_step(rd_ptr);
          fill   = fill - CNT_W'(1);
          // a drained queue restarts at slot zero
          if (fill == 0) flush();
          hit = 1'b1;
        end
      end
      OP_CLEAR: begin
        flush();
        hit = 1'b1;
      end
      default: begin
        // walk oldest to newest; an empty queue never matches
        pos = rd_ptr;
        for (int i = 0; i < fill; i++) begin
          if (slot_mem[pos] == v) hit = 1'b1;
          pos = ptr_step(pos);
        end
      end
    endcase
    r.ok        = hit;
    r.popped    = out_word;
    r.occupancy = fill;
    r.is_full   = (fill == cap);
    r.is_empty  = (fill == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input transaction, check every output one
  // ---------------------------------------------------------------------------
  result_t pending_results [$];
  int      n_open = 0;     // input transactions whose result has not come back
  int      n_acc  = 0;     // input transactions taken so far
  int      n_err  = 0;
  result_t want;
  result_t got;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
      flush();
      cap_reg = CAP_RESET;
      pending_results.delete();
      n_open <= 0;
      n_acc  <= 0;
    end else begin
      // The register write empties the queue as well.
      if (cfg_we) begin
        cap_reg = cfg_wdata;
        flush();
      end
      if (s_tvalid && s_tready) begin
        fifo_op(op_t'(s_tuser), s_tdata, want);
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.ok        = m_tuser;
        got.popped    = m_tdata[31:0];
        got.occupancy = m_tdata[36:32];
        got.is_full   = m_tdata[37];
        got.is_empty  = m_tdata[38];
        if (pending_results.size() == 0) begin
          if (n_err < REPORT_MAX)
            $display("%0t: result with no transaction outstanding", $realtime);
          n_err++;
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok || got.popped !== want.popped ||
              got.occupancy !== want.occupancy || got.is_full !== want.is_full ||
              got.is_empty !== want.is_empty) begin
            if (n_err < REPORT_MAX)
              $display({"%0t: mismatch exp ok=%0b popped=%0d occ=%0d full=%0b empty=%0b",
                        " | got ok=%0b popped=%0d occ=%0d full=%0b empty=%0b"},
                       $realtime, want.ok, want.popped, want.occupancy, want.is_full,
                       want.is_empty, got.ok, got.popped, got.occupancy, got.is_full,
                       got.is_empty);
            n_err++;
          end
        end
      end
      n_open <= n_open + (s_tvalid && s_tready) - (m_tvalid && m_tready);
      n_acc  <= n_acc + (s_tvalid && s_tready);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: send queued commands in bursts with random gaps between them
  // ---------------------------------------------------------------------------
  fifo_cmd_t cmd_queue [$];
  fifo_cmd_t next_cmd;
  int        burst_left = 0;
  int        gap_left   = 0;
  int        n_bursts   = 0;
  logic      drain_hold = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
      drain_hold <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (drain_hold) begin
        // hold off until every result in flight has been taken
        s_tvalid <= 1'b0;
        if (!s_tvalid && n_open == 0) drain_hold <= 1'b0;
      end else if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        next_cmd = cmd_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_cmd.value;
        s_tuser  <= next_cmd.kind;
        if (burst_left <= 1) begin
          // close the burst: pick the next length, the gap, and now and then
          // a full drain before sending more
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          n_bursts   <= n_bursts + 1;
          drain_hold <= (n_bursts % 8 == 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch stall pattern at random, timed from the counter of cycles
  // ---------------------------------------------------------------------------
  rdy_mode_t rdy_mode = RDY_OPEN;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (cyc % 64 == 0) rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
      case (rdy_mode)
        RDY_OPEN:   m_tready <= 1'b1;
        RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:    m_tready <= (cyc % 7 != 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int          n_queued = 0;
  logic [31:0] recent [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                              32'h1, 32'h2, 32'h3, 32'h4};
  logic [CAP_W-1:0] phase_caps [8] = '{5'd31, 5'd3, 5'd16, 5'd1, 5'd17, 5'd7, 5'd2,
                                       5'd12};

  task automatic queue_cmd(input op_t kind, input logic [31:0] v);
    fifo_cmd_t c;
    c.kind  = kind;
    c.value = v;
    cmd_queue.push_back(c);
    n_queued++;
  endtask

  // Full-range words mixed with extremes and a small pool, so that
  // duplicates and repeated keys show up.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      4, 5:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Wait for the block to go quiet, then program a new capacity.
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait (n_acc == n_queued && n_open == 0);
    repeat (3) @(posedge clk);
    cfg_wdata <= c;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Random traffic: fill-heavy in the first half, drain-heavy in the second,
  // searches keyed mostly on recently pushed words.
  task automatic random_phase(input int n_items);
    int          pick;
    logic [31:0] v;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_cmd(OP_CLEAR, $urandom);
      end else if (pick < 30) begin
        v = ($urandom_range(0, 9) < 7) ? recent[$urandom_range(0, 7)] : rand_word();
        queue_cmd(OP_SEARCH, v);
      end else if (pick < ((i < n_items / 2) ? 80 : 50)) begin
        v = rand_word();
        recent[$urandom_range(0, 7)] = v;
        queue_cmd(OP_PUSH, v);
      end else begin
        queue_cmd(OP_POP, $urandom);
      end
    end
  endtask

  initial begin
    wait (!rst);
    @(negedge clk);

    // Directed: empty queue corner cases, extreme words, hits and misses,
    // clear, then a search and a pop on the cleared queue.
    queue_cmd(OP_POP,    32'hdead_beef);
    queue_cmd(OP_SEARCH, 32'h0);
    queue_cmd(OP_PUSH,   32'h8000_0000);
    queue_cmd(OP_PUSH,   32'h7fff_ffff);
    queue_cmd(OP_PUSH,   32'h0);
    queue_cmd(OP_PUSH,   32'hffff_ffff);
    queue_cmd(OP_PUSH,   32'haaaa_aaaa);
    queue_cmd(OP_PUSH,   32'h5555_5555);
    queue_cmd(OP_SEARCH, 32'h7fff_ffff);
    queue_cmd(OP_SEARCH, 32'h5555_5555);
    queue_cmd(OP_SEARCH, 32'h1234_5678);
    queue_cmd(OP_POP,    32'h0);
    queue_cmd(OP_POP,    32'h0);
    queue_cmd(OP_CLEAR,  32'hffff_ffff);
    queue_cmd(OP_SEARCH, 32'h0);
    queue_cmd(OP_POP,    32'h0);

    // Zero capacity behaves as a single slot: second push is refused.
    set_capacity(5'd0);
    queue_cmd(OP_PUSH,   32'h0bad_cafe);
    queue_cmd(OP_PUSH,   32'h1111_1111);
    queue_cmd(OP_SEARCH, 32'h0bad_cafe);
    queue_cmd(OP_POP,    32'h0);
    queue_cmd(OP_POP,    32'h0);

    // Random part across several capacity settings, including out-of-range ones.
    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      random_phase(PHASE_LEN);
    end

    // Drain, then allow the longest search walk plus margin.
    wait (n_acc == n_queued && n_open == 0);
    repeat (40) @(posedge clk);
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
